// File: rtl/gpit_pkg.sv
package gpit_pkg;
  localparam int WIDTH = 64;
  localparam int DW = $clog2(WIDTH + 1);
  localparam int IW = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] poly_t;
  typedef logic [DW-1:0] deg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the input polynomial
    logic sq_init;  // start one modular squaring
    logic sq_step;  // one bit of the squaring
    logic gcd_init; // load a = f, b = s ^ x
    logic gcd_step; // one reduction step of the GCD
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic deg_le0;
    logic deg_eq1;
    logic f_bit0;
    logic sq_last;   // last bit of the squaring is being processed
    logic b_zero;
    logic a_one;
    logic rounds_done;
  } dp_sts_t;

  function automatic deg_t poly_deg(input poly_t p);
    deg_t d;
    d = '0;
    for (int k = 0; k < WIDTH; k++) begin
      if (p[k]) begin
        d = deg_t'(k);
      end
    end
    return d;
  endfunction
endpackage

// File: rtl/gpit_datapath.sv
module gpit_datapath
  import gpit_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  poly_t   in_poly,
  input  dp_cmd_t cmd,
  output dp_sts_t sts
);
  poly_t f_r, f_nxt;
  deg_t  d_r, d_nxt;
  poly_t s_r, s_nxt;
  poly_t acc_r, acc_nxt;
  deg_t  k_r, k_nxt;
  deg_t  i_r, i_nxt;
  poly_t a_r, a_nxt;
  poly_t b_r, b_nxt;
  deg_t  da_r, da_nxt;
  deg_t  db_r, db_nxt;
  logic  nz_r, nz_nxt;

  poly_t sh, x_poly;
  poly_t bsh;
  deg_t  dm1;
  logic  acc_top;
  logic  a_lead;

  assign x_poly = poly_t'(2);

  always_comb begin
    f_nxt = f_r;
    d_nxt = d_r;
    s_nxt = s_r;
    acc_nxt = acc_r;
    k_nxt = k_r;
    i_nxt = i_r;
    a_nxt = a_r;
    b_nxt = b_r;
    da_nxt = da_r;
    db_nxt = db_r;
    nz_nxt = nz_r;
    sh = {acc_r[WIDTH-2:0], 1'b0};
    dm1 = d_r - deg_t'(1);
    acc_top = acc_r[dm1[IW-1:0]];
    bsh = b_r << (da_r - db_r);
    a_lead = a_r[da_r[IW-1:0]];
    if (cmd.load) begin
      f_nxt = in_poly;
      d_nxt = poly_deg(in_poly);
      nz_nxt = |in_poly;
      s_nxt = x_poly;
      i_nxt = '0;
    end
    if (cmd.sq_init) begin
      acc_nxt = '0;
      k_nxt = d_r - deg_t'(1);
      i_nxt = i_r + deg_t'(1);
    end
    if (cmd.sq_step) begin
      // Shift-and-add multiply of s by s, reducing by f one bit at a time.
      acc_nxt = sh;
      if (acc_top) begin
        acc_nxt = acc_nxt ^ f_r;
      end
      if (s_r[k_r[IW-1:0]]) begin
        acc_nxt = acc_nxt ^ s_r;
      end
      k_nxt = k_r - deg_t'(1);
      if (k_r == '0) begin
        s_nxt = acc_nxt;
      end
    end
    if (cmd.gcd_init) begin
      a_nxt = f_r;
      da_nxt = d_r;
      b_nxt = s_r ^ x_poly;
      db_nxt = poly_deg(s_r ^ x_poly);
    end
    if (cmd.gcd_step) begin
      // Reduce a by b one leading term at a time; swap once deg a < deg b.
      if (da_r < db_r || a_r == '0) begin
        a_nxt = b_r;
        da_nxt = db_r;
        b_nxt = a_r;
        db_nxt = poly_deg(a_r);
      end else if (a_lead) begin
        a_nxt = a_r ^ bsh;
        if (da_r != '0) begin
          da_nxt = da_r - deg_t'(1);
        end
      end else begin
        if (da_r != '0) begin
          da_nxt = da_r - deg_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    d_r <= d_nxt;
    s_r <= s_nxt;
    acc_r <= acc_nxt;
    k_r <= k_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    da_r <= da_nxt;
    db_r <= db_nxt;
    nz_r <= nz_nxt;
    if (!rst_n) begin
      i_r <= '0;
    end else begin
      i_r <= i_nxt;
    end
  end

  always_comb begin
    sts.deg_le0 = !nz_r || d_r == '0;
    sts.deg_eq1 = nz_r && d_r == deg_t'(1);
    sts.f_bit0 = f_r[0];
    sts.sq_last = k_r == '0;
    sts.b_zero = b_r == '0;
    sts.a_one = a_r == poly_t'(1);
    sts.rounds_done = i_r >= (d_r >> 1);
  end
endmodule

// File: rtl/gpit_ctrl.sv
module gpit_ctrl
  import gpit_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output logic    out_irreducible,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SQ    = 6'b000100,
    S_GINIT = 6'b001000,
    S_GCD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic res_r, res_nxt;
  logic val_r, val_nxt;

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    val_nxt = 1'b0;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.deg_le0) begin
          res_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (sts.deg_eq1) begin
          res_nxt = sts.f_bit0;
          state_nxt = S_DONE;
        end else if (sts.rounds_done) begin
          res_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.sq_init = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) begin
          state_nxt = S_GINIT;
        end
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (sts.b_zero) begin
          if (sts.a_one) begin
            state_nxt = S_CHECK;
          end else begin
            res_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DONE: begin
        val_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      val_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      val_r <= val_nxt;
    end
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = val_r;
  assign out_irreducible = res_r;
endmodule

// File: rtl/gf2_poly_irreducibility_test.sv
// Ben-Or irreducibility test over GF(2), one polynomial at a time.
// Each round runs a bit-serial modular squaring of s and then a GCD of f with
// s ^ x; up to deg/2 rounds are run before f is declared irreducible.
// Throughput: one transaction per test; busy stays high until the result.
// The result is shown for one cycle on out_valid; the receiver cannot stall.
// Reset: synchronous active-low rst_n returns the controller to idle.
module gf2_poly_irreducibility_test
  import gpit_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  poly_t in_poly,
  output logic  out_valid,
  output logic  out_irreducible
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  gpit_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .out_irreducible(out_irreducible),
    .cmd(cmd), .sts(sts)
  );

  gpit_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_poly(in_poly), .cmd(cmd), .sts(sts)
  );
endmodule

// File: rtl/gpit_checker.sv
module gpit_checker
  import gpit_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  start,
  input logic  busy,
  input poly_t in_poly,
  input logic  out_valid,
  input logic  out_irreducible
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held too long");
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_zero_reducible: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_poly == '0 |=> ##2 out_valid && !out_irreducible)
    else $error("zero polynomial result");
endmodule

bind gf2_poly_irreducibility_test gpit_checker u_chk (.*);
